[rtl/quaternion_to_euler_angles_core_defines.svh]
// ----------------------------------------------------------------------------
// Quaternion to Euler angles: assertion macros
// Shared helpers for concurrent checks on clk with synchronous rst_n.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_CORE_DEFINES_SVH
`define QUATERNION_TO_EULER_ANGLES_CORE_DEFINES_SVH

// same-cycle implication
`define Q2E_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define Q2E_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/q2e_pkg.sv]
// ----------------------------------------------------------------------------
// q2e_pkg
// Types, constants and helper functions of the quaternion to Euler core.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int ROUND_SHIFT     = 30 - ANGLE_FRAC_BITS;

  localparam int SUM_W  = 34;   // Q.28 sums
  localparam int ANG_W  = 34;   // Q.30 angles
  localparam int LANE_W = 37;   // CORDIC x/y with growth
  localparam int SQ_W   = 58;   // square root remainder
  localparam int SQ_TOP = 56;   // exponent of the first root bit
  localparam int SQRT_STEPS = SQ_TOP / 2 + 1;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

  typedef struct packed {
    logic signed [SUM_W-1:0] sr;
    logic signed [SUM_W-1:0] cr;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] cy;
    logic signed [SUM_W-1:0] sp;
    logic                    sat;
  } side_t;

  typedef struct packed {
    logic signed [LANE_W-1:0] x;
    logic signed [LANE_W-1:0] y;
    logic signed [ANG_W-1:0]  z;
    logic                     zero;
  } lane_t;

  typedef lane_t [2:0] lanes_t;   // 0 roll, 1 pitch, 2 yaw

  typedef struct packed {
    logic sat;
    logic sneg;
  } meta_t;

  localparam int LN_ROLL  = 0;
  localparam int LN_PITCH = 1;
  localparam int LN_YAW   = 2;

  // atan(2^-i) in Q.30, rounded
  function automatic logic signed [ANG_W-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ANG_W-1:0] r;
    case (idx)
      5'd0:  r = 34'sd843314857;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043837;
      5'd3:  r = 34'sd133525159;
      5'd4:  r = 34'sd67021687;
      5'd5:  r = 34'sd33543516;
      5'd6:  r = 34'sd16775851;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194283;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048576;
      5'd11: r = 34'sd524288;
      5'd12: r = 34'sd262144;
      5'd13: r = 34'sd131072;
      5'd14: r = 34'sd65536;
      5'd15: r = 34'sd32768;
      5'd16: r = 34'sd16384;
      5'd17: r = 34'sd8192;
      5'd18: r = 34'sd4096;
      5'd19: r = 34'sd2048;
      5'd20: r = 34'sd1024;
      5'd21: r = 34'sd512;
      5'd22: r = 34'sd256;
      5'd23: r = 34'sd128;
      default: r = '0;
    endcase
    return r;
  endfunction

  // clamp, round half away from zero, keep low 16 bits
  function automatic logic [15:0] to_field(input logic signed [ANG_W-1:0] z,
                                           input logic signed [ANG_W-1:0] lim);
    logic signed [ANG_W-1:0] c;
    logic [ANG_W-1:0] mag;
    logic [ANG_W-1:0] rnd;
    logic [ANG_W-1:0] r;
    c = z;
    if (c > lim) c = lim;
    if (c < -lim) c = -lim;
    mag = (c < 0) ? ANG_W'(-c) : ANG_W'(c);
    rnd = (mag + (ANG_W'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
    r = (c < 0) ? -rnd : rnd;
    return r[15:0];
  endfunction

  localparam logic [14:0] PITCH_SAT_FIELD = 15'(to_field(HALF_PI_Q30, HALF_PI_Q30));

endpackage

[rtl/q2e_front.sv]
// ----------------------------------------------------------------------------
// q2e_front
// Products, sums and the radicand 1 - s^2 for the pitch square root.
// Four register stages.
// ----------------------------------------------------------------------------
module q2e_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [15:0]   quat_w,
  input  logic signed [15:0]   quat_x,
  input  logic signed [15:0]   quat_y,
  input  logic signed [15:0]   quat_z,
  output logic                 out_valid,
  output q2e_pkg::side_t       side_out,
  output logic [q2e_pkg::SQ_W-1:0] rem_out
);
  import q2e_pkg::*;

  logic [3:0] v_r;
  logic signed [31:0] wx_r, yz_r, xx_r, yy_r, wz_r, xy_r, zz_r, wy_r, zx_r;
  side_t s2_r, s3_r, s4_r;
  logic [27:0] hh_r, hl_r, ll_r;
  logic [SQ_W-1:0] rem_r;

  side_t s2_nxt;
  side_t s3_nxt;
  logic signed [SUM_W-1:0] sp_abs;
  logic [27:0] a_mag;
  logic [SQ_W-1:0] sq;

  always_comb begin
    s2_nxt.sr  = (SUM_W'(wx_r) + SUM_W'(yz_r)) <<< 1;
    s2_nxt.cr  = (SUM_W'(1) <<< 28) - ((SUM_W'(xx_r) + SUM_W'(yy_r)) <<< 1);
    s2_nxt.sy  = (SUM_W'(wz_r) + SUM_W'(xy_r)) <<< 1;
    s2_nxt.cy  = (SUM_W'(1) <<< 28) - ((SUM_W'(yy_r) + SUM_W'(zz_r)) <<< 1);
    s2_nxt.sp  = (SUM_W'(wy_r) - SUM_W'(zx_r)) <<< 1;
    s2_nxt.sat = 1'b0;
    s3_nxt     = s2_r;
    s3_nxt.sat = (s2_r.sp >= (SUM_W'(1) <<< 28)) || (s2_r.sp <= -(SUM_W'(1) <<< 28));
    sp_abs = (s2_r.sp < 0) ? -s2_r.sp : s2_r.sp;
    a_mag  = sp_abs[27:0];
    sq = (SQ_W'(hh_r) << 28) + (SQ_W'(hl_r) << 15) + SQ_W'(ll_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx_r <= quat_w * quat_x;
      yz_r <= quat_y * quat_z;
      xx_r <= quat_x * quat_x;
      yy_r <= quat_y * quat_y;
      wz_r <= quat_w * quat_z;
      xy_r <= quat_x * quat_y;
      zz_r <= quat_z * quat_z;
      wy_r <= quat_w * quat_y;
      zx_r <= quat_z * quat_x;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
      hh_r <= 28'(a_mag[27:14] * a_mag[27:14]);
      hl_r <= 28'(a_mag[27:14] * a_mag[13:0]);
      ll_r <= 28'(a_mag[13:0] * a_mag[13:0]);
      s4_r <= s3_r;
      rem_r <= (SQ_W'(1) << SQ_TOP) - sq;
    end
  end

  assign out_valid = v_r[3];
  assign side_out  = s4_r;
  assign rem_out   = rem_r;

endmodule

[rtl/q2e_sqrt_cell.sv]
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One digit of the restoring integer square root; passes the side data on.
// ----------------------------------------------------------------------------
module q2e_sqrt_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic [4:0]                step,
  input  logic                      in_valid,
  input  logic [q2e_pkg::SQ_W-1:0]  n_in,
  input  logic [q2e_pkg::SQ_W-1:0]  res_in,
  input  q2e_pkg::side_t            side_in,
  output logic                      out_valid,
  output logic [q2e_pkg::SQ_W-1:0]  n_out,
  output logic [q2e_pkg::SQ_W-1:0]  res_out,
  output q2e_pkg::side_t            side_out
);
  import q2e_pkg::*;

  logic            v_r;
  logic [SQ_W-1:0] n_r, res_r;
  side_t           side_r;
  logic [SQ_W-1:0] n_nxt, res_nxt, bit_v, trial;
  logic [5:0]      sh;

  always_comb begin
    sh    = 6'(SQ_TOP) - {step, 1'b0};
    bit_v = SQ_W'(1) << sh;
    trial = res_in + bit_v;
    if (n_in >= trial) begin
      n_nxt   = n_in - trial;
      res_nxt = (res_in >> 1) + bit_v;
    end else begin
      n_nxt   = n_in;
      res_nxt = res_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      res_r  <= res_nxt;
      side_r <= side_in;
    end
  end

  assign out_valid = v_r;
  assign n_out     = n_r;
  assign res_out   = res_r;
  assign side_out  = side_r;

endmodule

[rtl/q2e_cordic_cell.sv]
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC micro-rotation for the roll, pitch and yaw lanes.
// ----------------------------------------------------------------------------
module q2e_cordic_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [4:0]       step,
  input  logic             in_valid,
  input  q2e_pkg::lanes_t  lanes_in,
  input  q2e_pkg::meta_t   meta_in,
  output logic             out_valid,
  output q2e_pkg::lanes_t  lanes_out,
  output q2e_pkg::meta_t   meta_out
);
  import q2e_pkg::*;

  logic   v_r;
  lanes_t lanes_r;
  meta_t  meta_r;
  lanes_t lanes_nxt;
  logic signed [LANE_W-1:0] xs, ys;
  logic signed [ANG_W-1:0]  ang;

  always_comb begin
    ang = atan_q30(step);
    lanes_nxt = lanes_in;
    for (int k = 0; k < 3; k++) begin
      xs = lanes_in[k].x >>> step;
      ys = lanes_in[k].y >>> step;
      if (lanes_in[k].y >= 0) begin
        lanes_nxt[k].x = lanes_in[k].x + ys;
        lanes_nxt[k].y = lanes_in[k].y - xs;
        lanes_nxt[k].z = lanes_in[k].z + ang;
      end else begin
        lanes_nxt[k].x = lanes_in[k].x - ys;
        lanes_nxt[k].y = lanes_in[k].y + xs;
        lanes_nxt[k].z = lanes_in[k].z - ang;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lanes_r <= lanes_nxt;
      meta_r  <= meta_in;
    end
  end

  assign out_valid = v_r;
  assign lanes_out = lanes_r;
  assign meta_out  = meta_r;

endmodule

[rtl/quaternion_to_euler_angles_core.sv]
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_core
// Unit quaternion (Q1.14) to roll, pitch, yaw (Q2.13 radians; pitch Q1.13) by CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one quaternion per request, taken when in_valid is
//   high and in_stall low. Output channel out_*: one angle set per request,
//   taken when out_valid is high and out_stall low. Results leave in order.
//   The path holds four product/sum stages, 29 square-root digit cells
//   for the pitch cosine, one quadrant pre-rotation, the CORDIC cells,
//   and the output register.
//   Throughput is one request per cycle while in_stall is low.
//   The whole cell chain moves on one enable. It halts only when the output
//   register holds an untaken result and the last cell also holds one; then
//   in_stall is raised. Bubbles are squeezed out while the output waits.
//   Reset (rst_n low, synchronous) drops every request in flight and clears
//   out_valid; there is no other state.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_core_defines.svh"

module quaternion_to_euler_angles_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_roll_angle,
  output logic signed [14:0] out_pitch_angle,
  output logic signed [15:0] out_yaw_angle,
  output logic               out_pitch_saturated
);
  import q2e_pkg::*;

  logic en;
  logic last_v;

  logic            fr_v;
  side_t           fr_side;
  logic [SQ_W-1:0] fr_rem;

  logic            sq_v    [0:SQRT_STEPS];
  logic [SQ_W-1:0] sq_n    [0:SQRT_STEPS];
  logic [SQ_W-1:0] sq_res  [0:SQRT_STEPS];
  side_t           sq_side [0:SQRT_STEPS];

  logic   cd_v     [0:CORDIC_STAGES];
  lanes_t cd_lanes [0:CORDIC_STAGES];
  meta_t  cd_meta  [0:CORDIC_STAGES];

  lanes_t pre_nxt;
  lanes_t pre_r;
  meta_t  pre_meta_r;
  logic   pre_v_r;

  logic        out_valid_r;
  logic [15:0] roll_r, yaw_r;
  logic [14:0] pitch_r;
  logic        sat_r;
  logic [15:0] roll_nxt, yaw_nxt, pitch_full;
  logic signed [ANG_W-1:0] pz;
  lanes_t fin;
  meta_t  fin_meta;

  assign last_v   = cd_v[CORDIC_STAGES];
  assign en       = !(out_valid_r && out_stall && last_v);
  assign in_stall = !en;

  q2e_front u_front (
    .clk(clk), .rst_n(rst_n), .en(en), .in_valid(in_valid),
    .quat_w(in_quat_w), .quat_x(in_quat_x), .quat_y(in_quat_y), .quat_z(in_quat_z),
    .out_valid(fr_v), .side_out(fr_side), .rem_out(fr_rem)
  );

  assign sq_v[0]    = fr_v;
  assign sq_n[0]    = fr_rem;
  assign sq_res[0]  = '0;
  assign sq_side[0] = fr_side;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    q2e_sqrt_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .step(5'(g)),
      .in_valid(sq_v[g]), .n_in(sq_n[g]), .res_in(sq_res[g]), .side_in(sq_side[g]),
      .out_valid(sq_v[g+1]), .n_out(sq_n[g+1]), .res_out(sq_res[g+1]),
      .side_out(sq_side[g+1])
    );
  end

  // operand setup and quadrant pre-rotation for x < 0
  always_comb begin
    lane_t l;
    side_t s;
    s = sq_side[SQRT_STEPS];
    for (int k = 0; k < 3; k++) begin
      case (k)
        LN_ROLL: begin
          l.x = LANE_W'(s.cr);
          l.y = LANE_W'(s.sr);
        end
        LN_PITCH: begin
          l.x = LANE_W'(sq_res[SQRT_STEPS]);
          l.y = LANE_W'(s.sp);
        end
        default: begin
          l.x = LANE_W'(s.cy);
          l.y = LANE_W'(s.sy);
        end
      endcase
      l.z    = '0;
      l.zero = (l.x == 0) && (l.y == 0);
      if (l.x < 0) begin
        if (l.y >= 0) begin
          pre_nxt[k].x = l.y;
          pre_nxt[k].y = -l.x;
          pre_nxt[k].z = HALF_PI_Q30;
        end else begin
          pre_nxt[k].x = -l.y;
          pre_nxt[k].y = l.x;
          pre_nxt[k].z = -HALF_PI_Q30;
        end
      end else begin
        pre_nxt[k].x = l.x;
        pre_nxt[k].y = l.y;
        pre_nxt[k].z = l.z;
      end
      pre_nxt[k].zero = l.zero;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= 1'b0;
    end else if (en) begin
      pre_v_r <= sq_v[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_r           <= pre_nxt;
      pre_meta_r.sat  <= sq_side[SQRT_STEPS].sat;
      pre_meta_r.sneg <= sq_side[SQRT_STEPS].sp < 0;
    end
  end

  assign cd_v[0]     = pre_v_r;
  assign cd_lanes[0] = pre_r;
  assign cd_meta[0]  = pre_meta_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    q2e_cordic_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .step(5'(g)),
      .in_valid(cd_v[g]), .lanes_in(cd_lanes[g]), .meta_in(cd_meta[g]),
      .out_valid(cd_v[g+1]), .lanes_out(cd_lanes[g+1]), .meta_out(cd_meta[g+1])
    );
  end

  always_comb begin
    fin      = cd_lanes[CORDIC_STAGES];
    fin_meta = cd_meta[CORDIC_STAGES];
    roll_nxt = to_field(fin[LN_ROLL].zero ? '0 : fin[LN_ROLL].z, PI_Q30);
    yaw_nxt  = to_field(fin[LN_YAW].zero ? '0 : fin[LN_YAW].z, PI_Q30);
    if (fin_meta.sat) begin
      pz = fin_meta.sneg ? -HALF_PI_Q30 : HALF_PI_Q30;
    end else begin
      pz = fin[LN_PITCH].zero ? '0 : fin[LN_PITCH].z;
    end
    pitch_full = to_field(pz, HALF_PI_Q30);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && last_v) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && last_v) begin
      roll_r  <= roll_nxt;
      yaw_r   <= yaw_nxt;
      pitch_r <= pitch_full[14:0];
      sat_r   <= fin_meta.sat;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_roll_angle      = roll_r;
  assign out_pitch_angle     = pitch_r;
  assign out_yaw_angle       = yaw_r;
  assign out_pitch_saturated = sat_r;

  `Q2E_ASSERT_IMPL(a_stall_cause, in_stall, out_valid_r && last_v && out_stall,
                   "input stalled without a blocked result")
  `Q2E_ASSERT_NEXT(a_result_load, en && last_v, out_valid_r,
                   "finished request not loaded into output register")
  `Q2E_ASSERT_IMPL(a_sat_pitch, out_valid_r && out_pitch_saturated,
                   out_pitch_angle == PITCH_SAT_FIELD || out_pitch_angle == -PITCH_SAT_FIELD,
                   "saturated pitch is not +/- pi/2")

endmodule

[dv/q2e_checker.sv]
// ----------------------------------------------------------------------------
// q2e_checker
// Watches both channels of the quaternion to Euler core, predicts each angle
// set from the accepted quaternion and compares it with the delivered one.
// ----------------------------------------------------------------------------
module q2e_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_roll_angle,
  input  logic signed [14:0] out_pitch_angle,
  input  logic signed [15:0] out_yaw_angle,
  input  logic               out_pitch_saturated,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = q2e_pkg::CORDIC_STAGES;
  localparam int FRAC   = q2e_pkg::ANGLE_FRAC_BITS;
  localparam longint ONE_Q28 = 64'sd1 << 28;
  localparam longint PI_RAD  = 64'sd3373259426;
  localparam longint HPI_RAD = 64'sd1686629713;

  typedef struct {
    logic [15:0] roll;
    logic [14:0] pitch;
    logic [15:0] yaw;
    logic        sat;
  } angles_t;

  angles_t angle_queue[$];

  function automatic longint arctan_step(int i);
    longint tab[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                        33543516, 16775851, 8388437, 4194283, 2097149, 1048576,
                        524288, 262144, 131072, 65536, 32768, 16384, 8192,
                        4096, 2048, 1024, 512, 256, 128};
    return tab[i];
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HPI_RAD;
      end else begin
        t = x; x = -y; y = t; z = -HPI_RAD;
      end
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      xs = x >>> i;  // arithmetic shift floors
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + arctan_step(i);
      end else begin
        x = x - ys; y = y + xs; z = z - arctan_step(i);
      end
    end
    return z;
  endfunction

  function automatic logic [15:0] round_angle(longint z, longint lim);
    longint mag, r;
    if (z > lim) z = lim;
    if (z < -lim) z = -lim;
    mag = (z < 0) ? -z : z;
    mag = (mag + (64'sd1 << (30 - FRAC - 1))) >>> (30 - FRAC);
    r = (z < 0) ? -mag : mag;
    return r[15:0];
  endfunction

  function automatic angles_t euler_from_quat(longint w, longint x, longint y, longint z);
    angles_t a;
    longint sr, cr, sy, cy, sp, p, c;
    sr = 2 * (w * x + y * z);
    cr = ONE_Q28 - 2 * (x * x + y * y);
    sy = 2 * (w * z + x * y);
    cy = ONE_Q28 - 2 * (y * y + z * z);
    sp = 2 * (w * y - z * x);
    a.sat = 1'b0;
    if (sp >= ONE_Q28) begin
      p = HPI_RAD; a.sat = 1'b1;
    end else if (sp <= -ONE_Q28) begin
      p = -HPI_RAD; a.sat = 1'b1;
    end else begin
      c = int_sqrt((64'd1 << 56) - longint'(sp * sp));
      p = vector_angle(sp, c);
    end
    a.roll  = round_angle(vector_angle(sr, cr), PI_RAD);
    a.pitch = 15'(round_angle(p, HPI_RAD));
    a.yaw   = round_angle(vector_angle(sy, cy), PI_RAD);
    return a;
  endfunction

  assign pending = angle_queue.size();

  always @(posedge clk) begin
    angles_t e;
    if (!rst_n) begin
      angle_queue.delete();
      fail_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        angle_queue.push_back(euler_from_quat(in_quat_w, in_quat_x, in_quat_y,
                                              in_quat_z));
      if (out_valid && !out_stall) begin
        if (angle_queue.size() == 0) begin
          $error("unexpected result: no request outstanding");
          fail_count <= fail_count + 1;
        end else begin
          e = angle_queue.pop_front();
          if (out_roll_angle !== e.roll || out_pitch_angle !== e.pitch ||
              out_yaw_angle !== e.yaw || out_pitch_saturated !== e.sat)
            fail_count <= fail_count + 1;
          if (out_roll_angle !== e.roll)
            $error("roll_angle expected %0d got %0d", $signed(e.roll), out_roll_angle);
          if (out_pitch_angle !== e.pitch)
            $error("pitch_angle expected %0d got %0d", $signed(e.pitch), out_pitch_angle);
          if (out_yaw_angle !== e.yaw)
            $error("yaw_angle expected %0d got %0d", $signed(e.yaw), out_yaw_angle);
          if (out_pitch_saturated !== e.sat)
            $error("pitch_saturated expected %0d got %0d", e.sat, out_pitch_saturated);
        end
      end
    end
  end
endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the quaternion to Euler core: directed corner quaternions,
// then random unit and arbitrary ones under varying idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM  = 360;
  localparam int MAX_CYCLE = 400000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [15:0] out_roll_angle, out_yaw_angle;
  logic signed [14:0] out_pitch_angle;
  logic               out_pitch_saturated;
  int                 fail_count, pending;
  int                 send_idle_pct = 34, recv_idle_pct = 61;
  bit                 hold_off = 1'b0;
  int                 cycle = 0;

  quaternion_to_euler_angles_core uut (.*);
  q2e_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("quaternion_to_euler_angles_core: mismatch");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b1;
    else out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // called at a falling edge; returns at the falling edge after acceptance
  // with in_valid still high, the caller or the next idle drops it
  task automatic send_quat(input logic [15:0] w, x, y, z);
    logic stalled;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_quat_w <= w; in_quat_x <= x; in_quat_y <= y; in_quat_z <= z;
    forever begin
      // stall is settled between the falling edge and the next rising edge
      #1 stalled = in_stall;
      @(posedge clk);
      if (!stalled) break;
      @(negedge clk);
    end
    @(negedge clk);
  endtask

  task automatic send_random;
    real a, b, c, d, n;
    int mode;
    mode = $urandom_range(9);
    if (mode < 7) begin
      // unit quaternion with random direction
      a = $urandom_range(65535) - 32768.0; b = $urandom_range(65535) - 32768.0;
      c = $urandom_range(65535) - 32768.0; d = $urandom_range(65535) - 32768.0;
      if (mode == 6) begin
        // near gimbal lock: w ~ y, x ~ z ~ 0
        c = a; b = b / 512.0; d = d / 512.0;
      end
      n = $sqrt(a * a + b * b + c * c + d * d);
      if (n < 1.0) n = 1.0;
      send_quat(16'($rtoi(16384.0 * a / n)), 16'($rtoi(16384.0 * b / n)),
                16'($rtoi(16384.0 * c / n)), 16'($rtoi(16384.0 * d / n)));
    end else begin
      send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed corners
    send_quat(16384, 0, 0, 0);
    send_quat(0, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, -16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(0, 0, 0, -16384);
    send_quat(11585, 0, 11585, 0);
    send_quat(11585, 0, -11585, 0);
    send_quat(11586, 0, 11586, 0);
    send_quat(0, 11585, 0, 11585);
    send_quat(16384, 16384, 16384, 16384);
    send_quat(-16384, -16384, -16384, -16384);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(8192, -8192, 8192, -8192);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 61 : 0;
      recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 34 : 0;
      for (int i = 0; i < N_RANDOM / 3; i++) send_random();
    end
    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int i = 0; i < 120; i++) send_random();
        in_valid <= 1'b0;
      end
    join
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("quaternion_to_euler_angles_core: match");
    else
      $display("quaternion_to_euler_angles_core: mismatch");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/q2e_pkg.sv
rtl/q2e_front.sv
rtl/q2e_sqrt_cell.sv
rtl/q2e_cordic_cell.sv
rtl/quaternion_to_euler_angles_core.sv
dv/q2e_checker.sv
dv/tb.sv
